>>> hw/rtl/srf_pkg.sv
// Shared types, constants and saturation helpers for the restitution filter.
// No dependencies; imported by srf_ctrl, srf_datapath and the top level.
`default_nettype none

package srf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int MUL_W       = DATA_W + 1;
  localparam int WIDE_W      = ACC_W + 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COEF_CURRENT,
    REG_COEF_PREVIOUS,
    REG_COEF_OLDEST,
    REG_SAMPLE_PERIOD
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_MAC3,
    ST_I1_LO,
    ST_I1_HI,
    ST_I1_SUM,
    ST_I1_ACC,
    ST_I2_LO,
    ST_I2_HI,
    ST_I2_SUM,
    ST_I2_ACC
  } state_t;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MAC0,
    OP_MAC1,
    OP_MAC2,
    OP_MAC3,
    OP_I1_LO,
    OP_I1_HI,
    OP_I1_SUM,
    OP_I1_ACC,
    OP_I2_LO,
    OP_I2_HI,
    OP_I2_SUM,
    OP_I2_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   cfg_we;
  } cmd_t;

  function automatic logic wide_clips(input logic signed [WIDE_W-1:0] v);
    wide_clips = !((v[WIDE_W-1:ACC_W-1] == '0) || (v[WIDE_W-1:ACC_W-1] == '1));
  endfunction

  function automatic logic signed [ACC_W-1:0] wide_sat(input logic signed [WIDE_W-1:0] v);
    if (!wide_clips(v)) begin
      wide_sat = v[ACC_W-1:0];
    end else if (v[WIDE_W-1]) begin
      wide_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      wide_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [WIDE_W-1:0] widen(input logic signed [ACC_W-1:0] v);
    widen = {{(WIDE_W-ACC_W){v[ACC_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/srf_ctrl.sv
// Sequencer for the restitution filter: handshakes and step commands.
// Depends on srf_pkg.
`default_nettype none

module srf_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  output srf_pkg::cmd_t     cmd
);
  import srf_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   in_xfer;

  assign out_free = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_I2_ACC && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_xfer) state_next = ST_MAC0;
      ST_MAC0:   state_next = ST_MAC1;
      ST_MAC1:   state_next = ST_MAC2;
      ST_MAC2:   state_next = ST_MAC3;
      ST_MAC3:   state_next = ST_I1_LO;
      ST_I1_LO:  state_next = ST_I1_HI;
      ST_I1_HI:  state_next = ST_I1_SUM;
      ST_I1_SUM: state_next = ST_I1_ACC;
      ST_I1_ACC: state_next = ST_I2_LO;
      ST_I2_LO:  state_next = ST_I2_HI;
      ST_I2_HI:  state_next = ST_I2_SUM;
      ST_I2_SUM: state_next = ST_I2_ACC;
      ST_I2_ACC: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready  = (state == ST_IDLE) && !rst;
    s_tready   = (state == ST_IDLE) && !cfg_valid && !rst;
    cmd.cfg_we = cfg_valid && cfg_ready;
    cmd.op     = OP_HOLD;
    case (state)
      ST_IDLE:   cmd.op = in_xfer ? OP_LOAD : OP_HOLD;
      ST_MAC0:   cmd.op = OP_MAC0;
      ST_MAC1:   cmd.op = OP_MAC1;
      ST_MAC2:   cmd.op = OP_MAC2;
      ST_MAC3:   cmd.op = OP_MAC3;
      ST_I1_LO:  cmd.op = OP_I1_LO;
      ST_I1_HI:  cmd.op = OP_I1_HI;
      ST_I1_SUM: cmd.op = OP_I1_SUM;
      ST_I1_ACC: cmd.op = OP_I1_ACC;
      ST_I2_LO:  cmd.op = OP_I2_LO;
      ST_I2_HI:  cmd.op = OP_I2_HI;
      ST_I2_SUM: cmd.op = OP_I2_SUM;
      ST_I2_ACC: cmd.op = out_free ? OP_I2_ACC : OP_HOLD;
      default:   cmd.op = OP_HOLD;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/srf_datapath.sv
// Datapath: config registers, sample history, shared 33x33 multiplier,
// 66-bit saturating adder, integrators and output register. Depends on srf_pkg.
`default_nettype none

module srf_datapath #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire srf_pkg::cmd_t                      cmd,
  input  wire logic [srf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [srf_pkg::DATA_W-1:0]         cfg_data,
  input  wire logic [SAMPLE_WIDTH-1:0]            in_sample,
  input  wire logic                               in_last,
  output logic [srf_pkg::ACC_W-1:0]               out_disp,
  output logic                                    out_sat,
  output logic                                    out_last
);
  import srf_pkg::*;

  logic signed [DATA_W-1:0] coef_cur;
  logic signed [DATA_W-1:0] coef_prev;
  logic signed [DATA_W-1:0] coef_old;
  logic        [DATA_W-1:0] period;

  logic        [SAMPLE_WIDTH-1:0] x_cur;
  logic        [SAMPLE_WIDTH-1:0] x_prev;
  logic        [SAMPLE_WIDTH-1:0] x_old;
  logic                           last_in;
  logic                           clip;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  integ1;
  logic signed [ACC_W-1:0]  integ2;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [WIDE_W-1:0] prod;
  logic signed [WIDE_W-1:0] sum;
  logic        [DATA_W-1:0] part;

  logic signed [WIDE_W-1:0] add_a;
  logic signed [WIDE_W-1:0] add_b;
  logic signed [WIDE_W-1:0] add_y;
  logic signed [ACC_W-1:0]  add_sat;
  logic                     add_clip;

  function automatic logic signed [MUL_W-1:0] sx(input logic [SAMPLE_WIDTH-1:0] v);
    sx = {{(MUL_W-SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v};
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = {1'b0, period};
    case (cmd.op)
      OP_MAC0: begin
        mul_a = {coef_cur[DATA_W-1], coef_cur};
        mul_b = sx(x_cur);
      end
      OP_MAC1: begin
        mul_a = {coef_prev[DATA_W-1], coef_prev};
        mul_b = sx(x_prev);
      end
      OP_MAC2: begin
        mul_a = {coef_old[DATA_W-1], coef_old};
        mul_b = sx(x_old);
      end
      OP_I1_LO: mul_a = {1'b0, acc[DATA_W-1:0]};
      OP_I1_HI: mul_a = {acc[ACC_W-1], acc[ACC_W-1:DATA_W]};
      OP_I2_LO: mul_a = {1'b0, integ1[DATA_W-1:0]};
      OP_I2_HI: mul_a = {integ1[ACC_W-1], integ1[ACC_W-1:DATA_W]};
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    add_a = sum;
    add_b = prod;
    case (cmd.op)
      OP_MAC1:   add_a = widen(acc);
      OP_I1_ACC: add_b = widen(integ1);
      OP_I2_ACC: add_b = widen(integ2);
      default:   add_a = sum;
    endcase
    add_y    = add_a + add_b;
    add_sat  = wide_sat(add_y);
    add_clip = wide_clips(add_y);
  end

  always_ff @(posedge clk) begin
    prod <= WIDE_W'(mul_a * mul_b);
    case (cmd.op)
      OP_MAC1, OP_MAC2: sum <= add_y;
      OP_I1_HI, OP_I2_HI: part <= prod[2*DATA_W-1:DATA_W];
      OP_I1_SUM, OP_I2_SUM: sum <= prod + $signed({{(WIDE_W-DATA_W){1'b0}}, part});
      default: ;
    endcase
    if (cmd.op == OP_LOAD) begin
      x_cur   <= in_sample;
      last_in <= in_last;
    end
    if (cmd.op == OP_I2_ACC) begin
      out_disp <= integ2;
      out_sat  <= clip || add_clip;
      out_last <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_cur  <= '0;
      coef_prev <= '0;
      coef_old  <= '0;
      period    <= '0;
      x_prev    <= '0;
      x_old     <= '0;
      acc       <= '0;
      integ1    <= '0;
      integ2    <= '0;
      clip      <= 1'b0;
    end else if (cmd.cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_COEF_CURRENT:  coef_cur  <= cfg_data;
        REG_COEF_PREVIOUS: coef_prev <= cfg_data;
        REG_COEF_OLDEST:   coef_old  <= cfg_data;
        REG_SAMPLE_PERIOD: period    <= cfg_data;
        default: ;
      endcase
      x_prev <= '0;
      x_old  <= '0;
      acc    <= '0;
      integ1 <= '0;
      integ2 <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: clip <= 1'b0;
        OP_MAC3: begin
          acc    <= add_sat;
          clip   <= clip || add_clip;
          x_old  <= x_prev;
          x_prev <= x_cur;
        end
        OP_I1_ACC: begin
          integ1 <= add_sat;
          clip   <= clip || add_clip;
        end
        OP_I2_ACC: integ2 <= add_sat;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/seismometer_restitution_filter.sv
// Top level of the seismometer restitution filter: sequencer plus datapath.
// Depends on srf_pkg, srf_ctrl and srf_datapath.
//
//   channel  dir  payload
//   s_*      in   tdata: sample; tlast: block_end
//   m_*      out  tdata: displacement; tuser: saturated; tlast: block_end_out
//   cfg_*    in   cfg_index: register, cfg_data: value (any write clears state)
//
// Each sample is taken, then the three taps pass through the shared
// 33x33 multiplier and 66-bit adder, and each integration forms two partial
// products, combines them and does a saturating add.
// Reset is synchronous and clears coefficients, period and all filter state.
// The result sits in an output register; the next sample is taken while it
// waits, and the last step holds only while that register is still full.
`default_nettype none

module seismometer_restitution_filter #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  wire logic                                  s_tlast,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [srf_pkg::ACC_W-1:0]                  m_tdata,   // [63:0] displacement
  output logic                                       m_tuser,   // [0] saturated
  output logic                                       m_tlast,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [srf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [srf_pkg::DATA_W-1:0]            cfg_data
);
  import srf_pkg::*;

  cmd_t cmd;

  srf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  srf_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (s_tdata[SAMPLE_WIDTH-1:0]),
    .in_last   (s_tlast),
    .out_disp  (m_tdata),
    .out_sat   (m_tuser),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for seismometer_restitution_filter: directed table, then random phases.
// Expected displacement comes from a bit-accurate predictor kept in this file.
// Depends on srf_pkg and the filter RTL only.

module testbench;
  import srf_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int SETTLE_CYCLES  = 16;
  localparam int STALL_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 1130;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int PRINT_CAP      = 40;

  localparam logic signed [127:0] ACC_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] ACC_MIN = ~ACC_MAX;

  typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    reg_index_t   idx;
    logic [31:0]  value;
    logic [23:0]  smp;
    logic         last;
    bit           typed;
    logic [63:0]  want_disp;
    logic         want_sat;
  } stim_row_t;

  typedef struct {
    logic signed [63:0] displacement;
    logic               saturated;
    logic               block_end;
  } disp_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [23:0] sample
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [63:0] displacement
  logic        m_tuser;        // [0] saturated
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;

  // predictor state
  logic signed [31:0] coef_now, coef_one, coef_two;
  logic        [31:0] period;
  logic signed [23:0] hist1, hist2;
  logic signed [63:0] resp_acc, integ1, integ2;

  disp_expect_t pending_disp[$];
  stim_row_t    directed[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 27;
  int           recv_idle_pct = 86;
  bit           stall_request = 1'b0;

  seismometer_restitution_filter uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic out_of_range(input logic signed [127:0] v);
    return (v > ACC_MAX) || (v < ACC_MIN);
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
    if (v > ACC_MAX) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (v < ACC_MIN) return 64'sh8000_0000_0000_0000;
    return v[63:0];
  endfunction

  // floor(v * period / 2^32)
  function automatic logic signed [63:0] scale_by_period(input logic signed [63:0] v);
    logic signed [127:0] p;
    p = v * $signed({1'b0, period});
    p = p >>> 32;
    return p[63:0];
  endfunction

  task automatic clear_filter();
    hist1 = '0;
    hist2 = '0;
    resp_acc = '0;
    integ1 = '0;
    integ2 = '0;
  endtask

  task automatic apply_register(input reg_index_t idx, input logic [31:0] val);
    case (idx)
      REG_COEF_CURRENT:  coef_now = val;
      REG_COEF_PREVIOUS: coef_one = val;
      REG_COEF_OLDEST:   coef_two = val;
      REG_SAMPLE_PERIOD: period = val;
      default: ;
    endcase
    clear_filter();
  endtask

  task automatic predict_displacement(input logic signed [23:0] x, input logic last,
                                      output disp_expect_t e);
    logic signed [127:0] wsum;
    logic                clip;
    wsum = resp_acc;
    wsum = wsum + coef_now * x + coef_one * hist1 + coef_two * hist2;
    clip = out_of_range(wsum);
    resp_acc = clamp64(wsum);
    hist2 = hist1;
    hist1 = x;
    wsum = integ1 + scale_by_period(resp_acc);
    clip |= out_of_range(wsum);
    integ1 = clamp64(wsum);
    e.displacement = integ2;
    wsum = integ2 + scale_by_period(integ1);
    clip |= out_of_range(wsum);
    integ2 = clamp64(wsum);
    e.saturated = clip;
    e.block_end = last;
  endtask

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic [23:0] smp, input logic last, input bit typed,
                             input logic [63:0] want_disp, input logic want_sat);
    disp_expect_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_displacement($signed(smp), last, e);
    if (typed) begin
      e.displacement = want_disp;
      e.saturated = want_sat;
    end
    pending_disp.push_back(e);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_disp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_reg_row(input reg_index_t idx, input logic [31:0] val);
    stim_row_t r;
    r = '{ROW_REG, idx, val, '0, 1'b0, 1'b0, '0, 1'b0};
    directed.push_back(r);
  endtask

  task automatic add_sample_row(input logic [23:0] smp, input logic last, input bit typed,
                                input logic [63:0] want_disp, input logic want_sat);
    stim_row_t r;
    r = '{ROW_SAMPLE, REG_COEF_CURRENT, '0, smp, last, typed, want_disp, want_sat};
    directed.push_back(r);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3, 4: return 24'($urandom_range(1023)) - 24'd512;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return '0;
      default: return 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(4))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return 32'($urandom_range(32'h0400_0000, 1));
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    disp_expect_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_disp.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata, '0);
      end else begin
        e = pending_disp.pop_front();
        if (m_tdata !== e.displacement)
          report_mismatch("displacement", m_tdata, e.displacement);
        if (m_tuser !== e.saturated)
          report_mismatch("saturated", 64'(m_tuser), 64'(e.saturated));
        if (m_tlast !== e.block_end)
          report_mismatch("block_end_out", 64'(m_tlast), 64'(e.block_end));
      end
    end
  end

  initial begin
    int          sent;
    int          len;
    int          nwrites;
    bit          ramp;
    logic [23:0] ramp_smp;
    logic [31:0] ramp_coef;
    reg_index_t  idx;

    coef_now = '0;
    coef_one = '0;
    coef_two = '0;
    period = '0;
    clear_filter();

    // all coefficients zero after reset, then period zero keeps integrals still
    add_sample_row(24'h7FFFFF, 1'b0, 1'b1, '0, 1'b0);
    add_sample_row(24'h800000, 1'b1, 1'b1, '0, 1'b0);
    add_reg_row(REG_COEF_CURRENT, 32'h0100_0000);
    add_sample_row(24'h7FFFFF, 1'b0, 1'b1, '0, 1'b0);
    add_sample_row(24'h800000, 1'b1, 1'b1, '0, 1'b0);
    add_sample_row(24'h000001, 1'b0, 1'b1, '0, 1'b0);
    add_reg_row(REG_SAMPLE_PERIOD, 32'h0147_AE14);
    add_sample_row(24'h000100, 1'b0, 1'b1, '0, 1'b0);
    add_sample_row(24'hFFFF00, 1'b0, 1'b0, '0, 1'b0);
    add_sample_row(24'h123456, 1'b1, 1'b0, '0, 1'b0);
    // largest taps and period drive the integrals into clipping
    add_reg_row(REG_COEF_PREVIOUS, 32'h7FFF_FFFF);
    add_reg_row(REG_COEF_OLDEST, 32'h7FFF_FFFF);
    add_reg_row(REG_COEF_CURRENT, 32'h7FFF_FFFF);
    add_reg_row(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++)
      add_sample_row(24'h7FFFFF, (i == 11), 1'b0, '0, 1'b0);
    add_reg_row(REG_COEF_CURRENT, 32'h8000_0000);
    add_sample_row(24'h800000, 1'b0, 1'b0, '0, 1'b0);
    add_sample_row(24'h800000, 1'b0, 1'b0, '0, 1'b0);
    add_sample_row(24'h5A5A5A, 1'b1, 1'b0, '0, 1'b0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG)
        write_register(directed[i].idx, directed[i].value);
      else
        send_sample(directed[i].smp, directed[i].last, directed[i].typed,
                    directed[i].want_disp, directed[i].want_sat);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      ramp = ($urandom_range(11) == 0);
      if (ramp) begin
        ramp_coef = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        ramp_smp = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
        write_register(REG_COEF_CURRENT, ramp_coef);
        write_register(REG_COEF_PREVIOUS, ramp_coef);
        write_register(REG_COEF_OLDEST, ramp_coef);
        write_register(REG_SAMPLE_PERIOD, pick_period());
        len = $urandom_range(200, 170);
      end else begin
        if ($urandom_range(4) != 0) begin
          nwrites = $urandom_range(4, 1);
          repeat (nwrites) begin
            idx = reg_index_t'($urandom_range(3));
            write_register(idx, (idx == REG_SAMPLE_PERIOD) ? pick_period() : pick_coef());
          end
        end
        len = $urandom_range(60, 10);
      end
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        if (sent < RANDOM_ITEMS / 3) begin
          send_idle_pct = 27;
          recv_idle_pct = 86;
        end else if (sent < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 86;
          recv_idle_pct = 27;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (sent == 100)
          stall_request = 1'b1;
        if (sent == 600)
          drain_results();
        send_sample(ramp ? ramp_smp : pick_sample(), ($urandom_range(7) == 0),
                    1'b0, '0, 1'b0);
        sent++;
      end
    end

    drain_results();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (pending_disp.size() != 0)
      report_mismatch("results missing", 64'(pending_disp.size()), '0);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
